[hdl/lrdf_pkg.sv]
// shared types and codes for the line raster framebuffer
package lrdf_pkg;

  // operation codes of the input channel
  typedef enum logic [1:0] {
    OP_PLOT = 2'd0,
    OP_LINE = 2'd1,
    OP_READ = 2'd2,
    OP_SWAP = 2'd3
  } op_t;

  // command kinds after classification (a plot is a one-pixel line)
  typedef enum logic [1:0] {
    CMD_LINE = 2'd0,
    CMD_READ = 2'd1,
    CMD_SWAP = 2'd2
  } cmd_kind_t;

  // one classified command waiting for the back end
  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [11:0] x0;
    logic signed [11:0] y0;
    logic signed [11:0] x1;
    logic signed [11:0] y1;
    logic [12:0]        dx;
    logic [12:0]        dy;
    logic               sx_pos;
    logic               sy_pos;
    logic [11:0]        idx;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  // back end state
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LINE_INIT,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_OUT
  } back_state_t;

  // fixed point shift of the row reciprocal
  localparam int RC_SHIFT = 24;

endpackage

[hdl/lrdf_front.sv]
// front end: accepts beats, classifies them and queues commands
module lrdf_front #(
  parameter int BANK_WORDS = 2400
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_operation,
  input  logic signed [11:0]      in_start_x,
  input  logic signed [11:0]      in_start_y,
  input  logic signed [11:0]      in_end_x,
  input  logic signed [11:0]      in_end_y,
  input  logic [11:0]             in_word_index,
  input  logic                    init_busy,
  input  logic                    q_pop,
  output lrdf_pkg::queue_head_t   q_head
);

  lrdf_pkg::cmd_t  cmd;
  lrdf_pkg::op_t   op;
  logic            drop;
  logic            accept;
  logic            push;
  lrdf_pkg::cmd_t  entry_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  logic signed [12:0] ex0, ex1, ey0, ey1;

  // classify the incoming beat
  always_comb begin
    op  = lrdf_pkg::op_t'(in_operation);
    ex0 = 13'(in_start_x);
    ey0 = 13'(in_start_y);
    ex1 = (op == lrdf_pkg::OP_PLOT) ? 13'(in_start_x) : 13'(in_end_x);
    ey1 = (op == lrdf_pkg::OP_PLOT) ? 13'(in_start_y) : 13'(in_end_y);
    cmd.kind = lrdf_pkg::CMD_LINE;
    case (op)
      lrdf_pkg::OP_READ: cmd.kind = lrdf_pkg::CMD_READ;
      lrdf_pkg::OP_SWAP: cmd.kind = lrdf_pkg::CMD_SWAP;
      default:           cmd.kind = lrdf_pkg::CMD_LINE;
    endcase
    cmd.x0     = in_start_x;
    cmd.y0     = in_start_y;
    cmd.x1     = ex1[11:0];
    cmd.y1     = ey1[11:0];
    cmd.sx_pos = ex0 < ex1;
    cmd.sy_pos = ey0 < ey1;
    cmd.dx     = cmd.sx_pos ? 13'(ex1 - ex0) : 13'(ex0 - ex1);
    cmd.dy     = cmd.sy_pos ? 13'(ey1 - ey0) : 13'(ey0 - ey1);
    cmd.idx    = in_word_index;
    drop = (op == lrdf_pkg::OP_READ) && (32'(in_word_index) >= BANK_WORDS);
  end

  assign in_stall = (cnt_r == 2'd2) || init_busy;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && !drop;

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, q_pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd;
    end
  end

  assign q_head.valid = cnt_r != 2'd0;
  assign q_head.cmd   = entry_r[rd_ptr_r];

  // queue bookkeeping checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> cnt_r == 2'd2)
    else $error("queue grew past full");

endmodule

[hdl/lrdf_back.sv]
// back end: line stepper, bank memories, clear sweep and change readout
module lrdf_back #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int WORD_BITS     = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrdf_pkg::queue_head_t q_head,
  output logic                  q_pop,
  output logic                  init_busy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_row,
  output logic [8:0]            out_column_base,
  output logic [31:0]           out_light_mask,
  output logic [31:0]           out_dark_mask
);

  localparam int WPR        = (SCREEN_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int BANK_WORDS = WPR * SCREEN_HEIGHT;
  localparam int ADDR_W     = $clog2(BANK_WORDS);
  localparam int WB_SHIFT   = $clog2(WORD_BITS);
  localparam int RECIP      = (1 << lrdf_pkg::RC_SHIFT) / WPR;

  lrdf_pkg::back_state_t state_r, state_nxt;

  logic                   front_bank_r;
  logic                   clear_both_r;
  logic [ADDR_W-1:0]      clr_cnt_r;
  logic signed [11:0]     x_r, y_r, x1_r, y1_r;
  logic [12:0]            dx_r, dy_r;
  logic                   sx_pos_r, sy_pos_r;
  logic signed [14:0]     err_r;
  logic [ADDR_W-1:0]      pix_addr_r;
  logic [WB_SHIFT-1:0]    pix_bit_r;
  logic                   pix_on_r;
  logic [11:0]            idx_r;
  logic [11:0]            q0_r;

  logic [WORD_BITS-1:0]   bank0_mem [BANK_WORDS];
  logic [WORD_BITS-1:0]   bank1_mem [BANK_WORDS];
  logic [WORD_BITS-1:0]   rd0_r, rd1_r;
  logic                   we0, we1;
  logic [ADDR_W-1:0]      wa, ra;
  logic [WORD_BITS-1:0]   wd;
  logic [WORD_BITS-1:0]   cur_w, prev_w;

  logic                   out_free, out_load;
  logic                   clr_last, line_done;
  logic                   pix_on;
  logic [ADDR_W-1:0]      pix_addr;
  logic signed [14:0]     dxs, dys;
  logic                   step_x, step_y;
  logic [23:0]            rem0, rem;
  logic                   rem_ge;
  logic [11:0]            row_q;
  logic [35:0]            prod;
  logic [WORD_BITS+31:0]  light_ext, dark_ext;

  // pixel address of the current line point and its screen test
  always_comb begin
    pix_on = (x_r >= 0) && (13'(x_r) < 13'(SCREEN_WIDTH)) &&
             (y_r >= 0) && (13'(y_r) < 13'(SCREEN_HEIGHT));
    pix_addr = ADDR_W'(32'($unsigned(y_r)) * WPR) +
               ADDR_W'($unsigned(x_r) >> WB_SHIFT);
  end

  // bresenham step terms
  always_comb begin
    dxs    = $signed({2'b00, dx_r});
    dys    = $signed({2'b00, dy_r});
    step_x = err_r > -dxs;
    step_y = err_r < dys;
  end

  assign clr_last  = clr_cnt_r == ADDR_W'(BANK_WORDS - 1);
  assign line_done = (x_r == x1_r) && (y_r == y1_r);
  assign out_free  = !out_valid || !out_stall;
  assign init_busy = clear_both_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrdf_pkg::ST_IDLE: begin
        if (q_head.valid) begin
          case (q_head.cmd.kind)
            lrdf_pkg::CMD_READ: state_nxt = lrdf_pkg::ST_RD_OUT;
            lrdf_pkg::CMD_SWAP: state_nxt = lrdf_pkg::ST_CLEAR;
            default:            state_nxt = lrdf_pkg::ST_LINE_INIT;
          endcase
        end
      end
      lrdf_pkg::ST_CLEAR:     if (clr_last) state_nxt = lrdf_pkg::ST_IDLE;
      lrdf_pkg::ST_LINE_INIT: state_nxt = lrdf_pkg::ST_PIX_RD;
      lrdf_pkg::ST_PIX_RD:    state_nxt = lrdf_pkg::ST_PIX_WR;
      lrdf_pkg::ST_PIX_WR: begin
        state_nxt = line_done ? lrdf_pkg::ST_IDLE : lrdf_pkg::ST_PIX_RD;
      end
      lrdf_pkg::ST_RD_OUT:    if (out_free) state_nxt = lrdf_pkg::ST_IDLE;
      default:                state_nxt = lrdf_pkg::ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    q_pop    = 1'b0;
    we0      = 1'b0;
    we1      = 1'b0;
    wa       = pix_addr_r;
    wd       = (front_bank_r ? rd1_r : rd0_r) | (WORD_BITS'(1) << pix_bit_r);
    ra       = pix_addr;
    out_load = 1'b0;
    case (state_r)
      lrdf_pkg::ST_IDLE: begin
        q_pop = q_head.valid;
        ra    = ADDR_W'(q_head.cmd.idx);
      end
      lrdf_pkg::ST_CLEAR: begin
        wa  = clr_cnt_r;
        wd  = '0;
        we0 = clear_both_r || !front_bank_r;
        we1 = clear_both_r || front_bank_r;
      end
      lrdf_pkg::ST_PIX_WR: begin
        we0 = pix_on_r && !front_bank_r;
        we1 = pix_on_r && front_bank_r;
      end
      lrdf_pkg::ST_RD_OUT: begin
        // keep the read word in place while the result register is held
        ra       = ADDR_W'(idx_r);
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lrdf_pkg::ST_CLEAR;
      front_bank_r <= 1'b0;
      clear_both_r <= 1'b1;
      clr_cnt_r    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lrdf_pkg::ST_IDLE && q_head.valid &&
          q_head.cmd.kind == lrdf_pkg::CMD_SWAP) begin
        front_bank_r <= !front_bank_r;
        clr_cnt_r    <= '0;
      end
      if (state_r == lrdf_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_last) begin
          clear_both_r <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // row estimate by reciprocal, corrected on the way out
  assign prod = 36'(q_head.cmd.idx) * 36'(RECIP);

  always_comb begin
    rem0   = 24'(idx_r) - 24'(32'(q0_r) * WPR);
    rem_ge = rem0 >= 24'(WPR);
    rem    = rem_ge ? rem0 - 24'(WPR) : rem0;
    row_q  = rem_ge ? q0_r + 12'd1 : q0_r;
  end

  // line stepper and read datapath
  always_ff @(posedge clk) begin
    case (state_r)
      lrdf_pkg::ST_IDLE: begin
        x_r      <= q_head.cmd.x0;
        y_r      <= q_head.cmd.y0;
        x1_r     <= q_head.cmd.x1;
        y1_r     <= q_head.cmd.y1;
        dx_r     <= q_head.cmd.dx;
        dy_r     <= q_head.cmd.dy;
        sx_pos_r <= q_head.cmd.sx_pos;
        sy_pos_r <= q_head.cmd.sy_pos;
        idx_r    <= q_head.cmd.idx;
        q0_r     <= prod[lrdf_pkg::RC_SHIFT +: 12];
      end
      lrdf_pkg::ST_LINE_INIT: begin
        err_r <= (dx_r > dy_r) ? $signed({3'b000, dx_r[12:1]})
                               : -$signed({3'b000, dy_r[12:1]});
      end
      lrdf_pkg::ST_PIX_RD: begin
        pix_addr_r <= pix_addr;
        pix_bit_r  <= x_r[WB_SHIFT-1:0];
        pix_on_r   <= pix_on;
      end
      lrdf_pkg::ST_PIX_WR: begin
        err_r <= err_r - (step_x ? dys : 15'sd0) + (step_y ? dxs : 15'sd0);
        if (step_x) x_r <= sx_pos_r ? x_r + 12'sd1 : x_r - 12'sd1;
        if (step_y) y_r <= sy_pos_r ? y_r + 12'sd1 : y_r - 12'sd1;
      end
      default: ;
    endcase
  end

  // bank memories
  always_ff @(posedge clk) begin
    if (we0) bank0_mem[wa] <= wd;
    rd0_r <= bank0_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (we1) bank1_mem[wa] <= wd;
    rd1_r <= bank1_mem[ra];
  end

  // change masks against the previous frame
  always_comb begin
    cur_w     = front_bank_r ? rd1_r : rd0_r;
    prev_w    = front_bank_r ? rd0_r : rd1_r;
    light_ext = {32'b0, cur_w & ~prev_w};
    dark_ext  = {32'b0, prev_w & ~cur_w};
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row         <= row_q[7:0];
      out_column_base <= 9'(rem << WB_SHIFT);
      out_light_mask  <= light_ext[31:0];
      out_dark_mask   <= dark_ext[31:0];
    end
  end

  // engine checks
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    (we0 || we1) |-> (state_r == lrdf_pkg::ST_CLEAR || state_r == lrdf_pkg::ST_PIX_WR))
    else $error("bank write outside clear or pixel write");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == lrdf_pkg::ST_IDLE)
    else $error("queue popped while busy");
  a_swap_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.cmd.kind == lrdf_pkg::CMD_SWAP) |=> front_bank_r != $past(front_bank_r))
    else $error("swap did not exchange banks");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while held");
  a_init_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_both_r |-> state_r == lrdf_pkg::ST_CLEAR)
    else $error("work started before reset clear finished");

endmodule

[hdl/line_raster_diff_framebuffer_unit.sv]
// top level of the double-buffered 1bpp framebuffer with line drawing
// Usage: commands arrive on the in_ channel (valid/stall); a beat is taken when
// in_valid is high and in_stall low. Plot and line set pixels in the drawing
// bank, swap exchanges the banks and clears the new drawing bank, read returns
// one word's light and dark change masks on the out_ channel (valid/stall).
// Only an in-range read gives a result; the other commands give none.
// Flow: commands pass a two-entry queue into a single engine. A line or plot
// sets up once and then does one read-modify-write of the bank memory per pixel,
// a read loads a registered result, and a swap runs the clear sweep over all
// WORDS_PER_ROW * SCREEN_HEIGHT words of the new drawing bank.
// Reset: both banks are swept to zero in parallel, with in_stall held high
// throughout; bank zero draws.
// Receiver stall: the result register holds its beat; the engine waits on the
// next read and the queue keeps taking commands until it is full.
module line_raster_diff_framebuffer_unit #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int WORD_BITS     = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [11:0] in_start_x,
  input  logic signed [11:0] in_start_y,
  input  logic signed [11:0] in_end_x,
  input  logic signed [11:0] in_end_y,
  input  logic [11:0]        in_word_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_row,
  output logic [8:0]         out_column_base,
  output logic [31:0]        out_light_mask,
  output logic [31:0]        out_dark_mask
);

  localparam int WPR        = (SCREEN_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int BANK_WORDS = WPR * SCREEN_HEIGHT;

  lrdf_pkg::queue_head_t q_head;
  logic                  q_pop;
  logic                  init_busy;

  // command intake and queue
  lrdf_front #(
    .BANK_WORDS(BANK_WORDS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_word_index (in_word_index),
    .init_busy     (init_busy),
    .q_pop         (q_pop),
    .q_head        (q_head)
  );

  // drawing engine and banks
  lrdf_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .WORD_BITS     (WORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_column_base (out_column_base),
    .out_light_mask  (out_light_mask),
    .out_dark_mask   (out_dark_mask)
  );

endmodule

[dv/line_raster_diff_framebuffer_unit_checker.sv]
// checker for the line raster framebuffer: predicts change words and compares results
module line_raster_diff_framebuffer_unit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [11:0] in_start_x,
  input  logic signed [11:0] in_start_y,
  input  logic signed [11:0] in_end_x,
  input  logic signed [11:0] in_end_y,
  input  logic [11:0]        in_word_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_row,
  input  logic [8:0]         out_column_base,
  input  logic [31:0]        out_light_mask,
  input  logic [31:0]        out_dark_mask,
  output int                 fail_count,
  output int                 words_waiting,
  output int                 words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH     = 320;
  localparam int HEIGHT    = 240;
  localparam int ROW_WORDS = WIDTH / 32;
  localparam int BANK_SIZE = ROW_WORDS * HEIGHT;

  typedef struct packed {
    logic [7:0]  row;
    logic [8:0]  column_base;
    logic [31:0] light;
    logic [31:0] dark;
  } change_word_t;

  // shadow of both banks and the drawing bank number
  bit [31:0]    shadow_bank [2][BANK_SIZE];
  bit           drawing_bank;
  change_word_t change_queue[$];

  initial begin
    fail_count    = 0;
    words_checked = 0;
    drawing_bank  = 1'b0;
    foreach (shadow_bank[b, w]) shadow_bank[b][w] = '0;
  end

  assign words_waiting = change_queue.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // set one pixel of the drawing bank, off-screen pixels dropped
  function automatic void set_pixel(input int x, input int y);
    if (x < 0 || x >= WIDTH || y < 0 || y >= HEIGHT) return;
    shadow_bank[drawing_bank][y * ROW_WORDS + x / 32][x % 32] = 1'b1;
  endfunction

  // bresenham walk from start to end
  function automatic void draw_segment(input int x0, input int y0, input int x1, input int y1);
    int dx, dy, sx, sy, err, e2;
    dx  = (x0 < x1) ? x1 - x0 : x0 - x1;
    dy  = (y0 < y1) ? y1 - y0 : y0 - y1;
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = (dx > dy) ? dx / 2 : -(dy / 2);
    forever begin
      set_pixel(x0, y0);
      if (x0 == x1 && y0 == y1) break;
      e2 = err;
      if (e2 > -dx) begin
        err -= dy;
        x0  += sx;
      end
      if (e2 < dy) begin
        err += dx;
        y0  += sy;
      end
    end
  endfunction

  // update the shadow on each accepted command beat
  always @(posedge clk) begin
    change_word_t cw;
    int idx;
    if (rst_n && in_valid && !in_stall) begin
      case (lrdf_pkg::op_t'(in_operation))
        lrdf_pkg::OP_PLOT: set_pixel(int'(in_start_x), int'(in_start_y));
        lrdf_pkg::OP_LINE: draw_segment(int'(in_start_x), int'(in_start_y),
                                        int'(in_end_x), int'(in_end_y));
        lrdf_pkg::OP_READ: begin
          idx = int'(in_word_index);
          if (idx < BANK_SIZE) begin
            cw.row         = 8'(idx / ROW_WORDS);
            cw.column_base = 9'((idx % ROW_WORDS) * 32);
            cw.light       = shadow_bank[drawing_bank][idx] & ~shadow_bank[!drawing_bank][idx];
            cw.dark        = shadow_bank[!drawing_bank][idx] & ~shadow_bank[drawing_bank][idx];
            change_queue.push_back(cw);
          end
        end
        lrdf_pkg::OP_SWAP: begin
          drawing_bank = !drawing_bank;
          for (int w = 0; w < BANK_SIZE; w++) shadow_bank[drawing_bank][w] = '0;
        end
        default: ;
      endcase
    end
  end

  // compare each accepted result beat with the oldest expected word
  always @(posedge clk) begin
    change_word_t cw;
    if (rst_n && out_valid && !out_stall) begin
      if (change_queue.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        fail_count++;
      end else begin
        cw = change_queue.pop_front();
        words_checked++;
        if (out_row !== cw.row) report_mismatch("row", out_row, cw.row);
        if (out_column_base !== cw.column_base)
          report_mismatch("column_base", out_column_base, cw.column_base);
        if (out_light_mask !== cw.light) report_mismatch("light_mask", out_light_mask, cw.light);
        if (out_dark_mask !== cw.dark) report_mismatch("dark_mask", out_dark_mask, cw.dark);
      end
    end
  end

endmodule

[dv/line_raster_diff_framebuffer_unit_tb.sv]
// testbench top for the line raster framebuffer: stimulus, stalls and verdict
module line_raster_diff_framebuffer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 40000000;
  localparam int RANDOM_ITEMS = 800;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_operation = lrdf_pkg::OP_PLOT;
  logic signed [11:0] in_start_x = '0;
  logic signed [11:0] in_start_y = '0;
  logic signed [11:0] in_end_x = '0;
  logic signed [11:0] in_end_y = '0;
  logic [11:0]        in_word_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_row;
  logic [8:0]         out_column_base;
  logic [31:0]        out_light_mask;
  logic [31:0]        out_dark_mask;

  int fail_count, words_waiting, words_checked;
  int cycles = 0;
  int commands_sent = 0;
  bit hold_request = 1'b0;

  always #1 clk = ~clk;

  line_raster_diff_framebuffer_unit i_dut (.*);

  line_raster_diff_framebuffer_unit_checker i_checker (.*);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // result receiver: random stalls, calm stretches and one long hold on request
  initial begin
    int calm;
    int r;
    calm = 0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (500) @(negedge clk);
        hold_request = 1'b0;
      end else if (r < 2) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        if (calm > 0) calm--;
        else if (r > 97) calm = $urandom_range(50, 300);
        out_stall <= (calm == 0) && (r < 30);
      end
    end
  end

  // offer one command beat and wait for it to be taken
  task automatic send_beat(input lrdf_pkg::op_t op, input logic [11:0] sx,
                           input logic [11:0] sy, input logic [11:0] ex,
                           input logic [11:0] ey, input logic [11:0] widx);
    bit stalled;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_start_x    <= sx;
    in_start_y    <= sy;
    in_end_x      <= ex;
    in_end_y      <= ey;
    in_word_index <= widx;
    // stall is registered, so its value between edges is the one the next edge sees
    forever begin
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
      @(negedge clk);
    end
    commands_sent++;
  endtask

  // sender gap, mostly short with the odd long one
  task automatic sender_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 95) n = $urandom_range(1, 4);
    else n = $urandom_range(20, 120);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_waiting != 0) @(negedge clk);
  endtask

  function automatic logic [11:0] near_col();
    return 12'($urandom_range(0, 399) - 40);
  endfunction

  function automatic logic [11:0] near_row();
    return 12'($urandom_range(0, 319) - 40);
  endfunction

  function automatic logic [11:0] any_coord();
    return 12'($urandom_range(0, 4095));
  endfunction

  // word index that holds a given on-screen pixel, or a random one
  function automatic logic [11:0] word_of(input logic signed [11:0] x,
                                          input logic signed [11:0] y);
    if (x >= 0 && x < 320 && y >= 0 && y < 240) return 12'(y * 10 + x / 32);
    return 12'($urandom_range(0, 2399));
  endfunction

  initial begin
    logic signed [11:0] ax, ay, bx, by;
    int r;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, clipping, line shapes, read limits, swap
    send_beat(lrdf_pkg::OP_PLOT, 12'd0, 12'd0, 12'hfff, 12'hfff, 12'hfff);
    send_beat(lrdf_pkg::OP_PLOT, 12'd319, 12'd239, 12'd0, 12'd0, 12'd0);
    send_beat(lrdf_pkg::OP_PLOT, -12'sd1, 12'd0, 12'd0, 12'd0, 12'd0);
    send_beat(lrdf_pkg::OP_PLOT, 12'd320, 12'd5, 12'd0, 12'd0, 12'd0);
    send_beat(lrdf_pkg::OP_PLOT, 12'h800, 12'h800, 12'h7ff, 12'h7ff, 12'd0);
    send_beat(lrdf_pkg::OP_PLOT, 12'h7ff, 12'h7ff, 12'h800, 12'h800, 12'd0);
    send_beat(lrdf_pkg::OP_LINE, -12'sd10, -12'sd10, 12'd330, 12'd250, 12'd0);
    send_beat(lrdf_pkg::OP_LINE, 12'd40, 12'd0, 12'd40, 12'd239, 12'd0);
    send_beat(lrdf_pkg::OP_LINE, 12'd319, 12'd100, 12'd0, 12'd100, 12'd0);
    send_beat(lrdf_pkg::OP_LINE, 12'd77, 12'd33, 12'd77, 12'd33, 12'd0);
    send_beat(lrdf_pkg::OP_LINE, 12'd200, 12'd10, 12'd190, 12'd90, 12'd0);
    send_beat(lrdf_pkg::OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_beat(lrdf_pkg::OP_READ, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'd2399);
    send_beat(lrdf_pkg::OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 12'd2400);
    send_beat(lrdf_pkg::OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 12'hfff);
    send_beat(lrdf_pkg::OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 12'd1001);
    send_beat(lrdf_pkg::OP_SWAP, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    send_beat(lrdf_pkg::OP_PLOT, 12'd1, 12'd0, 12'd0, 12'd0, 12'd0);
    send_beat(lrdf_pkg::OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_beat(lrdf_pkg::OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 12'd1001);
    send_beat(lrdf_pkg::OP_READ, 12'd0, 12'd0, 12'd0, 12'd0, 12'd2399);

    // pause until the results are home, then fill the queue against a held receiver
    wait_drained();
    hold_request = 1'b1;
    for (int i = 0; i < 16; i++)
      send_beat(lrdf_pkg::OP_READ, 12'd0, 12'd0, 12'd0, 12'd0,
                12'($urandom_range(0, 2399)));

    // random frames: draw, read back changes, now and then swap
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (r < 4) begin
        send_beat(lrdf_pkg::OP_SWAP, any_coord(), any_coord(), any_coord(), any_coord(),
                  any_coord());
      end else if (r < 30) begin
        ax = ($urandom_range(0, 9) == 0) ? any_coord() : near_col();
        ay = ($urandom_range(0, 9) == 0) ? any_coord() : near_row();
        send_beat(lrdf_pkg::OP_PLOT, ax, ay, any_coord(), any_coord(), any_coord());
      end else if (r < 65) begin
        r  = $urandom_range(0, 99);
        ax = near_col();
        ay = near_row();
        if (r < 88) begin
          bx = ax + 12'($urandom_range(0, 80) - 40);
          by = ay + 12'($urandom_range(0, 80) - 40);
        end else if (r < 98) begin
          bx = near_col();
          by = near_row();
        end else begin
          ax = any_coord();
          ay = any_coord();
          bx = any_coord();
          by = any_coord();
        end
        send_beat(lrdf_pkg::OP_LINE, ax, ay, bx, by, any_coord());
      end else begin
        r = $urandom_range(0, 99);
        send_beat(lrdf_pkg::OP_READ, any_coord(), any_coord(), any_coord(), any_coord(),
                  (r < 10) ? 12'($urandom_range(2400, 4095)) :
                  (r < 60) ? word_of(ax, ay) : 12'($urandom_range(0, 2399)));
      end
      sender_gap();
    end

    // drain, then let a trailing swap or line finish
    wait_drained();
    repeat (3000) @(negedge clk);
    $display("sent %0d commands (plots, lines, change reads, swaps) with random stalls",
             commands_sent);
    $display("checked %0d change words in %0d cycles", words_checked, cycles);
    if (fail_count == 0 && words_waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
